[rtl/tbs_pkg.sv]
package tbs_pkg;

	localparam int COORD_FRAC_BITS = 4;
	localparam int PIXEL_COORD_BITS = 12;
	localparam int VTX_W = 16;
	localparam int COLOR_W = 8;
	localparam int COLOR_MAX = 255;
	localparam int EDGE_W = 36;
	localparam int AREA_W = 36;
	localparam int NUM_W = EDGE_W + COLOR_W + 3;
	localparam int QUEUE_DEPTH = 4;

	// Operation codes of the op field.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SHADE = 1'b1;

	typedef logic signed [PIXEL_COORD_BITS-1:0] pix_t;

	// Bounding box carried with every result.
	typedef struct packed {
		logic [PIXEL_COORD_BITS-1:0] x_min;
		logic [PIXEL_COORD_BITS-1:0] x_max;
		logic [PIXEL_COORD_BITS-1:0] y_min;
		logic [PIXEL_COORD_BITS-1:0] y_max;
	} box_t;

	// One classified item as it leaves the front part.
	typedef struct packed {
		logic shade;
		logic signed [EDGE_W-1:0] e0;
		logic signed [EDGE_W-1:0] e1;
		logic signed [EDGE_W-1:0] e2;
		logic signed [AREA_W-1:0] area;
		logic [3*COLOR_W-1:0] c0;
		logic [3*COLOR_W-1:0] c1;
		logic [3*COLOR_W-1:0] c2;
		box_t box;
	} work_t;

endpackage

[rtl/tbs_front.sv]
module tbs_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic op,
	input  logic [1:0] vertex_slot,
	input  logic signed [tbs_pkg::VTX_W-1:0] vertex_x,
	input  logic signed [tbs_pkg::VTX_W-1:0] vertex_y,
	input  logic [7:0] vertex_red,
	input  logic [7:0] vertex_green,
	input  logic [7:0] vertex_blue,
	input  logic signed [tbs_pkg::PIXEL_COORD_BITS-1:0] pixel_x,
	input  logic signed [tbs_pkg::PIXEL_COORD_BITS-1:0] pixel_y,
	input  logic adv,
	output logic valid_s2,
	output tbs_pkg::work_t work_s2
);
	localparam int VW = tbs_pkg::VTX_W;
	localparam int EW = tbs_pkg::EDGE_W;
	localparam int AW = tbs_pkg::AREA_W;
	localparam int FB = tbs_pkg::COORD_FRAC_BITS;
	localparam int PB = tbs_pkg::PIXEL_COORD_BITS;

	logic signed [VW-1:0] cx_q [3];
	logic signed [VW-1:0] cy_q [3];
	logic [23:0] col_q [3];
	logic signed [AW-1:0] area_q;
	logic signed [VW-1:0] nx [3];
	logic signed [VW-1:0] ny [3];

	// Stage 1 registers: products of the edge functions.
	logic valid_s1, shade_s1;
	logic signed [EW-1:0] pa_s1 [3];
	logic signed [EW-1:0] pb_s1 [3];
	logic signed [EW-1:0] pc_s1 [3];

	logic signed [EW-1:0] px, py;
	logic load_hit;

	assign px = EW'(pixel_x) <<< FB;
	assign py = EW'(pixel_y) <<< FB;
	assign load_hit = in_valid && adv && op == tbs_pkg::OP_LOAD && vertex_slot != 2'd3;

	// Corner set after this load.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nx[k] = cx_q[k];
			ny[k] = cy_q[k];
		end
		if (load_hit) begin
			nx[vertex_slot] = vertex_x;
			ny[vertex_slot] = vertex_y;
		end
	end

	// Corner store and doubled area; area uses the updated corners.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				cx_q[k] <= '0;
				cy_q[k] <= '0;
				col_q[k] <= '0;
			end
			area_q <= '0;
		end else if (load_hit) begin
			cx_q[vertex_slot] <= vertex_x;
			cy_q[vertex_slot] <= vertex_y;
			col_q[vertex_slot] <= {vertex_red, vertex_green, vertex_blue};
			area_q <= AW'(nx[0]) * (AW'(ny[1]) - AW'(ny[2]))
				+ AW'(ny[0]) * (AW'(nx[2]) - AW'(nx[1]))
				+ AW'(nx[1]) * AW'(ny[2]) - AW'(ny[1]) * AW'(nx[2]);
		end
	end

	// Edge products; edge k uses corners k+1 and k+2.
	always_ff @(posedge clk) begin
		if (adv) begin
			shade_s1 <= op;
			for (int k = 0; k < 3; k++) begin
				pa_s1[k] <= px * (EW'(cy_q[(k+1)%3]) - EW'(cy_q[(k+2)%3]));
				pb_s1[k] <= py * (EW'(cx_q[(k+2)%3]) - EW'(cx_q[(k+1)%3]));
				pc_s1[k] <= EW'(cx_q[(k+1)%3]) * EW'(cy_q[(k+2)%3])
					- EW'(cy_q[(k+1)%3]) * EW'(cx_q[(k+2)%3]);
			end
		end
	end

	function automatic logic [PB-1:0] trunc(input logic signed [VW-1:0] v);
		logic signed [VW:0] t;
		t = {v[VW-1], v} + ((v < 0) ? (VW+1)'((1 << FB) - 1) : (VW+1)'(0));
		return PB'(t >>> FB);
	endfunction

	function automatic logic signed [VW-1:0] mn(input logic signed [VW-1:0] a,
		input logic signed [VW-1:0] b, input logic signed [VW-1:0] c);
		logic signed [VW-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [VW-1:0] mx(input logic signed [VW-1:0] a,
		input logic signed [VW-1:0] b, input logic signed [VW-1:0] c);
		logic signed [VW-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	// Stage 2: sum edges, attach area, colors and box of current corners.
	always_ff @(posedge clk) begin
		if (adv) begin
			work_s2.shade <= shade_s1;
			work_s2.e0 <= pa_s1[0] + pb_s1[0] + pc_s1[0];
			work_s2.e1 <= pa_s1[1] + pb_s1[1] + pc_s1[1];
			work_s2.e2 <= pa_s1[2] + pb_s1[2] + pc_s1[2];
			work_s2.area <= area_q;
			work_s2.c0 <= col_q[0];
			work_s2.c1 <= col_q[1];
			work_s2.c2 <= col_q[2];
			work_s2.box.x_min <= trunc(mn(cx_q[0], cx_q[1], cx_q[2]));
			work_s2.box.x_max <= trunc(mx(cx_q[0], cx_q[1], cx_q[2]));
			work_s2.box.y_min <= trunc(mn(cy_q[0], cy_q[1], cy_q[2]));
			work_s2.box.y_max <= trunc(mx(cy_q[0], cy_q[1], cy_q[2]));
		end
	end

	// Valid bits of the front pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

endmodule

[rtl/tbs_queue.sv]
module tbs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] push_data,
	input  logic pop,
	output logic [WIDTH-1:0] pop_data,
	output logic not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;

	assign not_empty = count != '0;
	assign pop_data = mem_q[rd_q];

	// Circular buffer with occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

[rtl/tbs_divider.sv]
module tbs_divider #(
	parameter int NW = 48,
	parameter int DW = 37,
	parameter int QW = 9
) (
	input  logic clk,
	input  logic en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);
	// Restoring division, one quotient bit per stage; the quotient is
	// saturated to QW bits by a pre-check of the top stage.
	logic [NW-1:0] rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [QW-1:0] q_s [QW+1];
	logic sat_s [QW+1];

	always_comb begin
		rem_s[0] = num;
		den_s[0] = den;
		q_s[0] = '0;
		sat_s[0] = (num >> QW) >= NW'(den);
	end

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int SH = QW - 1 - i;
		logic [NW-1:0] sub;
		logic take;
		assign sub = NW'(den_s[i]) << SH;
		assign take = (rem_s[i] >> SH) >= NW'(den_s[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? rem_s[i] - sub : rem_s[i];
				den_s[i+1] <= den_s[i];
				q_s[i+1] <= q_s[i] | (take ? QW'(1) << SH : '0);
				sat_s[i+1] <= sat_s[i];
			end
		end
	end

	assign quo = sat_s[QW] ? '1 : q_s[QW];

endmodule

[rtl/tbs_back.sv]
module tbs_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  tbs_pkg::work_t work,
	input  logic en,
	output logic out_valid,
	output logic covered,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output tbs_pkg::box_t box
);
	localparam int EW = tbs_pkg::EDGE_W;
	localparam int NW = tbs_pkg::NUM_W + 2;
	localparam int DW = tbs_pkg::AREA_W + 1;
	localparam int QW = 9;
	localparam int LAT = QW + 3;

	// Stage 1: normalize sign, test coverage.
	logic cov_s1;
	logic [EW-1:0] e_s1 [3];
	logic [tbs_pkg::AREA_W-1:0] d_s1;
	logic [23:0] c_s1 [3];
	tbs_pkg::box_t box_s1;
	logic signed [EW-1:0] ea [3];
	logic neg;

	always_comb begin
		neg = work.area < 0;
		ea[0] = neg ? -work.e0 : work.e0;
		ea[1] = neg ? -work.e1 : work.e1;
		ea[2] = neg ? -work.e2 : work.e2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cov_s1 <= work.shade && work.area != 0 && ea[0] >= 0 && ea[1] >= 0 && ea[2] >= 0;
			for (int k = 0; k < 3; k++) e_s1[k] <= ea[k];
			d_s1 <= neg ? -work.area : work.area;
			c_s1[0] <= work.c0;
			c_s1[1] <= work.c1;
			c_s1[2] <= work.c2;
			box_s1 <= work.box;
		end
	end

	// Stage 2: weighted color products, then stage 3: sums and rounding terms.
	logic [EW+7:0] p_s2 [3][3];
	logic [tbs_pkg::AREA_W-1:0] d_s2;
	logic cov_s2;
	tbs_pkg::box_t box_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++)
				for (int k = 0; k < 3; k++)
					p_s2[c][k] <= e_s1[k] * c_s1[k][23-8*c -: 8];
			d_s2 <= d_s1;
			cov_s2 <= cov_s1;
			box_s2 <= box_s1;
		end
	end

	logic [NW-1:0] n_s3 [3];
	logic [DW-1:0] d_s3;
	logic cov_s3;
	tbs_pkg::box_t box_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++)
				n_s3[c] <= ((NW'(p_s2[c][0]) + NW'(p_s2[c][1]) + NW'(p_s2[c][2])) << 1)
					+ NW'(d_s2);
			d_s3 <= DW'(d_s2) << 1;
			cov_s3 <= cov_s2;
			box_s3 <= box_s2;
		end
	end

	logic [QW-1:0] q [3];
	for (genvar c = 0; c < 3; c++) begin : g_div
		tbs_divider #(.NW(NW), .DW(DW), .QW(QW)) u_div (
			.clk(clk), .en(en), .num(n_s3[c]), .den(d_s3), .quo(q[c])
		);
	end

	// Side pipeline matching divider latency.
	logic cov_d [QW];
	tbs_pkg::box_t box_d [QW];
	always_ff @(posedge clk) begin
		if (en) begin
			cov_d[0] <= cov_s3;
			box_d[0] <= box_s3;
			for (int i = 1; i < QW; i++) begin
				cov_d[i] <= cov_d[i-1];
				box_d[i] <= box_d[i-1];
			end
		end
	end

	function automatic logic [7:0] clamp(input logic [QW-1:0] v);
		return (v > QW'(tbs_pkg::COLOR_MAX)) ? 8'(tbs_pkg::COLOR_MAX) : v[7:0];
	endfunction

	assign covered = cov_d[QW-1];
	assign red = covered ? clamp(q[0]) : '0;
	assign green = covered ? clamp(q[1]) : '0;
	assign blue = covered ? clamp(q[2]) : '0;
	assign box = box_d[QW-1];

	// Valid shift line of the back pipeline.
	logic [LAT-1:0] v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[LAT-2:0], in_valid};
	end
	assign out_valid = v_q[LAT-1];

endmodule

[rtl/triangle_barycentric_shader.sv]
// Triangle barycentric shader with Gouraud color.
// Input channel: in_valid/in_stall with op, vertex and pixel fields. op 0
// loads one triangle corner (slot 3 is ignored); op 1 shades one pixel.
// Output channel: out_valid/out_stall with covered, RGB and bounding box.
// Every input transfer yields exactly one output transfer, in order.
// Throughput is one item per cycle while neither in_stall nor out_stall
// holds. An item passes the front part (edge products, edge sums), the queue
// and the back part (sign fix, products, sums and a 9-stage restoring
// divider).
// The front part stalls only when the queue cannot take what it holds in
// flight; the back part stalls as one pipeline while out_stall holds a
// valid result. Reset clears the corners and area to zero and empties all
// pipelines.
module triangle_barycentric_shader (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic op,
	input  logic [1:0] vertex_slot,
	input  logic signed [15:0] vertex_x,
	input  logic signed [15:0] vertex_y,
	input  logic [7:0] vertex_red,
	input  logic [7:0] vertex_green,
	input  logic [7:0] vertex_blue,
	input  logic signed [tbs_pkg::PIXEL_COORD_BITS-1:0] pixel_x,
	input  logic signed [tbs_pkg::PIXEL_COORD_BITS-1:0] pixel_y,
	output logic out_valid,
	input  logic out_stall,
	output logic covered,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic signed [tbs_pkg::PIXEL_COORD_BITS-1:0] box_x_min,
	output logic signed [tbs_pkg::PIXEL_COORD_BITS-1:0] box_x_max,
	output logic signed [tbs_pkg::PIXEL_COORD_BITS-1:0] box_y_min,
	output logic signed [tbs_pkg::PIXEL_COORD_BITS-1:0] box_y_max
);
	localparam int QD = tbs_pkg::QUEUE_DEPTH + 2;
	localparam int WW = $bits(tbs_pkg::work_t);

	logic adv, f_valid, q_ne, q_pop, b_en;
	logic [$clog2(QD+1)-1:0] q_cnt;
	tbs_pkg::work_t f_work, q_work;
	tbs_pkg::box_t b_box;

	// Front advances while the queue has room for everything in flight.
	assign adv = q_cnt <= ($clog2(QD+1))'(QD - 3);
	assign in_stall = !adv;

	tbs_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .op(op),
		.vertex_slot(vertex_slot), .vertex_x(vertex_x), .vertex_y(vertex_y),
		.vertex_red(vertex_red), .vertex_green(vertex_green), .vertex_blue(vertex_blue),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .adv(adv),
		.valid_s2(f_valid), .work_s2(f_work)
	);

	tbs_queue #(.WIDTH(WW), .DEPTH(QD)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(adv && f_valid), .push_data(f_work),
		.pop(q_pop), .pop_data(q_work), .not_empty(q_ne), .count(q_cnt)
	);

	// Back pipeline moves unless its head result is held by the receiver.
	assign b_en = !(out_valid && out_stall);
	assign q_pop = b_en && q_ne;

	tbs_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_ne), .work(q_work), .en(b_en),
		.out_valid(out_valid), .covered(covered), .red(red), .green(green),
		.blue(blue), .box(b_box)
	);

	assign box_x_min = b_box.x_min;
	assign box_x_max = b_box.x_max;
	assign box_y_min = b_box.y_min;
	assign box_y_max = b_box.y_max;

endmodule
